// File: rtl/enbq_pkg.sv
// Shared types, constants and helpers for the encoder and button qualifier.
// No dependencies; used by enbq_quad, enbq_debounce and the top level.
package enbq_pkg;

    localparam int NUM_SWITCHES = 5;
    localparam int TIMER_BITS   = 16;
    localparam int NUM_ROLES    = 5;   // encsw, btn1, btn2, es1, es2
    localparam int LEVEL_BITS   = 5;
    localparam int CMP_BITS     = (TIMER_BITS > 16) ? TIMER_BITS : 16;

    // switch roles
    localparam int SW_ENC  = 0;
    localparam int SW_BTN1 = 1;
    localparam int SW_BTN2 = 2;
    localparam int SW_ES1  = 3;
    localparam int SW_ES2  = 4;

    // configuration register indexes
    localparam logic [7:0] CFG_COUNTS_PER_DETENT = 8'd0;
    localparam logic [7:0] CFG_DEBOUNCE_MS       = 8'd1;
    localparam logic [7:0] CFG_LONG_PRESS_MS     = 8'd2;
    localparam logic [7:0] CFG_ACTIVE_LOW_MASK   = 8'd3;

    localparam logic [4:0]  RST_COUNTS_PER_DETENT = 5'd4;
    localparam logic [7:0]  RST_DEBOUNCE_MS       = 8'd30;
    localparam logic [15:0] RST_LONG_PRESS_MS     = 16'd800;
    localparam logic [4:0]  RST_ACTIVE_LOW_MASK   = 5'd7;

    localparam logic [1:0] PHASES_IDLE = 2'b11;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

    // quadrature direction codes
    localparam logic signed [1:0] DIR_NONE = 2'sd0;
    localparam logic signed [1:0] DIR_UP   = 2'sd1;
    localparam logic signed [1:0] DIR_DOWN = -2'sd1;

    typedef struct packed {
        logic stable_prev;
        logic stable;
        logic changed;
    } t_sw_status;

    typedef struct packed {
        logic signed [1:0]  detent_step;
        logic signed [31:0] raw_count;
        logic encoder_press;
        logic button1_press;
        logic button2_short;
        logic button2_long;
        logic endstop1_level;
        logic endstop2_level;
        logic endstop1_rise;
        logic endstop2_rise;
        logic user_activity;
        logic endstop_changed;
    } t_result;

    // {previous phases, current phases} -> count direction; illegal moves give none
    function automatic logic signed [1:0] quad_dir(input logic [3:0] trans);
        logic signed [1:0] d;
        unique case (trans)
            4'b1101, 4'b0100, 4'b0010, 4'b1011: d = DIR_DOWN;
            4'b1110, 4'b0111, 4'b0001, 4'b1000: d = DIR_UP;
            default:                            d = DIR_NONE;
        endcase
        return d;
    endfunction

    function automatic logic [TIMER_BITS-1:0] tick_sat(input logic [TIMER_BITS-1:0] t);
        return (t == TIMER_MAX) ? t : t + 1'b1;
    endfunction

endpackage

// File: rtl/enbq_quad.sv
// Quadrature decoder lane: raw count and detent bank.
// Depends on enbq_pkg.
module enbq_quad (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_phase_a,
    input  logic               i_phase_b,
    input  logic [4:0]         i_counts_per_detent,
    output logic signed [1:0]  o_detent_step,
    output logic signed [31:0] o_raw_count
);

    logic [1:0]         r_prev;
    logic [31:0]        r_count;
    logic signed [5:0]  r_resid;
    logic [1:0]         n_prev;
    logic [31:0]        n_count;
    logic signed [5:0]  n_resid;
    logic signed [1:0]  dir;
    logic signed [6:0]  resid_sum;
    logic signed [6:0]  cpd;

    always_comb begin
        n_prev    = {i_phase_a, i_phase_b};
        dir       = enbq_pkg::quad_dir({r_prev, n_prev});
        n_count   = r_count + 32'(signed'(dir));
        resid_sum = 7'(r_resid) + 7'(dir);
        cpd       = (i_counts_per_detent == 5'd0) ? 7'sd1 : signed'({2'b00, i_counts_per_detent});
        o_detent_step = enbq_pkg::DIR_NONE;
        n_resid       = resid_sum[5:0];
        if (resid_sum >= cpd) begin
            o_detent_step = enbq_pkg::DIR_UP;
            n_resid       = 6'(resid_sum - cpd);
        end else if (resid_sum <= -cpd) begin
            o_detent_step = enbq_pkg::DIR_DOWN;
            n_resid       = 6'(resid_sum + cpd);
        end
        o_raw_count = signed'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= enbq_pkg::PHASES_IDLE;
            r_count <= '0;
            r_resid <= '0;
        end else if (i_en) begin
            r_prev  <= n_prev;
            r_count <= n_count;
            r_resid <= n_resid;
        end
    end

endmodule

// File: rtl/enbq_debounce.sv
// One switch lane: polarity, settle timer and accepted state.
// Depends on enbq_pkg.
module enbq_debounce (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_tick,
    input  logic                    i_level,
    input  logic                    i_low_act,
    input  logic [7:0]              i_debounce_ms,
    output enbq_pkg::t_sw_status    o_status
);

    logic                              r_last_raw;
    logic                              r_stable;
    logic [enbq_pkg::TIMER_BITS-1:0]   r_timer;
    logic                              n_stable;
    logic [enbq_pkg::TIMER_BITS-1:0]   n_timer;
    logic                              raw;
    logic                              settled;

    always_comb begin
        raw     = i_level ^ i_low_act;
        n_timer = i_tick ? enbq_pkg::tick_sat(r_timer) : r_timer;
        if (raw != r_last_raw) begin
            n_timer = '0;
        end
        settled  = n_timer > enbq_pkg::TIMER_BITS'(i_debounce_ms);
        n_stable = settled ? raw : r_stable;
        o_status.stable_prev = r_stable;
        o_status.stable      = n_stable;
        o_status.changed     = n_stable != r_stable;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw <= 1'b0;
            r_stable   <= 1'b0;
            r_timer    <= '0;
        end else if (i_en) begin
            r_last_raw <= raw;
            r_stable   <= n_stable;
            r_timer    <= n_timer;
        end
    end

endmodule

// File: rtl/encoder_and_button_qualifier_top.sv
// Top level: config registers, encoder lane, switch lanes, event merge and
// two-entry result queue. Depends on enbq_pkg, enbq_quad, enbq_debounce.
//
// Usage:
//   Input channel (i_valid/o_ready) carries one pin sample per transfer: the
//   ms tick flag, both encoder phases and five raw switch levels.
//   Result channel (o_valid/i_ready) returns exactly one result per sample.
//   Config channel (i_cfg_valid/o_cfg_ready) is always ready; write only
//   while no result is outstanding.
// Output: a result enters the queue as its sample transfers and shows once earlier results are taken.
// Throughput: one sample per clock. Every lane finishes its update in the
//   accepting cycle; the two-entry result queue lets a sample transfer while
//   one result waits, and o_ready drops only with both entries full.
// Reset (synchronous, active low): registers return to 4 counts per detent,
//   30 ms debounce, 800 ms long press, mask 7; phases idle high, counts,
//   timers and switch states cleared, queue empty.
// Receiver stall: results stay in the queue unchanged; intake stops once
//   two results are waiting.
module encoder_and_button_qualifier_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // sample channel
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_ms_tick,
    input  logic               i_phase_a,
    input  logic               i_phase_b,
    input  logic [4:0]         i_switch_levels,
    // result channel
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [1:0]  o_detent_step,
    output logic signed [31:0] o_raw_count,
    output logic               o_encoder_press,
    output logic               o_button1_press,
    output logic               o_button2_short,
    output logic               o_button2_long,
    output logic               o_endstop1_level,
    output logic               o_endstop2_level,
    output logic               o_endstop1_rise,
    output logic               o_endstop2_rise,
    output logic               o_user_activity,
    output logic               o_endstop_changed,
    // configuration channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    localparam int NSW = enbq_pkg::NUM_SWITCHES;

    logic [4:0]  r_cpd;
    logic [7:0]  r_debounce_ms;
    logic [15:0] r_long_ms;
    logic [4:0]  r_low_mask;

    logic                             r_long_done;
    logic [enbq_pkg::TIMER_BITS-1:0]  r_hold;
    logic                             n_long_done;
    logic [enbq_pkg::TIMER_BITS-1:0]  n_hold;

    enbq_pkg::t_result r_q [2];
    logic [1:0]        r_cnt;
    enbq_pkg::t_result n_res;

    logic in_xfer;
    logic out_xfer;

    logic signed [1:0]  detent_step;
    logic signed [31:0] raw_count;

    enbq_pkg::t_sw_status sw_st [NSW];
    logic [enbq_pkg::NUM_ROLES-1:0] role_prev;
    logic [enbq_pkg::NUM_ROLES-1:0] role_stable;
    logic [enbq_pkg::NUM_ROLES-1:0] role_changed;
    logic enc_p, b1_p, b2_s, b2_l;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = r_cnt != 2'd2;
    assign o_valid     = r_cnt != 2'd0;
    assign in_xfer     = i_valid && o_ready;
    assign out_xfer    = o_valid && i_ready;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpd         <= enbq_pkg::RST_COUNTS_PER_DETENT;
            r_debounce_ms <= enbq_pkg::RST_DEBOUNCE_MS;
            r_long_ms     <= enbq_pkg::RST_LONG_PRESS_MS;
            r_low_mask    <= enbq_pkg::RST_ACTIVE_LOW_MASK;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                enbq_pkg::CFG_COUNTS_PER_DETENT: r_cpd         <= i_cfg_data[4:0];
                enbq_pkg::CFG_DEBOUNCE_MS:       r_debounce_ms <= i_cfg_data[7:0];
                enbq_pkg::CFG_LONG_PRESS_MS:     r_long_ms     <= i_cfg_data;
                enbq_pkg::CFG_ACTIVE_LOW_MASK:   r_low_mask    <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    enbq_quad u_quad (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_en                (in_xfer),
        .i_phase_a           (i_phase_a),
        .i_phase_b           (i_phase_b),
        .i_counts_per_detent (r_cpd),
        .o_detent_step       (detent_step),
        .o_raw_count         (raw_count)
    );

    // switch lanes; lanes past the five pins see level 0, active high
    for (genvar g = 0; g < NSW; g++) begin : g_sw
        logic lvl;
        logic lowact;
        if (g < enbq_pkg::LEVEL_BITS) begin : g_pin
            assign lvl    = i_switch_levels[g];
            assign lowact = r_low_mask[g];
        end else begin : g_nopin
            assign lvl    = 1'b0;
            assign lowact = 1'b0;
        end
        enbq_debounce u_sw (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_en          (in_xfer),
            .i_tick        (i_ms_tick),
            .i_level       (lvl),
            .i_low_act     (lowact),
            .i_debounce_ms (r_debounce_ms),
            .o_status      (sw_st[g])
        );
    end

    // roles without a lane are never active
    for (genvar k = 0; k < enbq_pkg::NUM_ROLES; k++) begin : g_role
        if (k < NSW) begin : g_have
            assign role_prev[k]    = sw_st[k].stable_prev;
            assign role_stable[k]  = sw_st[k].stable;
            assign role_changed[k] = sw_st[k].changed;
        end else begin : g_none
            assign role_prev[k]    = 1'b0;
            assign role_stable[k]  = 1'b0;
            assign role_changed[k] = 1'b0;
        end
    end

    // merge stage: button 2 hold logic and event flags
    always_comb begin
        enc_p = role_changed[enbq_pkg::SW_ENC] && role_stable[enbq_pkg::SW_ENC];
        b1_p  = role_changed[enbq_pkg::SW_BTN1] && role_stable[enbq_pkg::SW_BTN1];

        n_hold      = i_ms_tick ? enbq_pkg::tick_sat(r_hold) : r_hold;
        n_long_done = r_long_done;
        b2_s        = 1'b0;
        b2_l        = 1'b0;
        if (role_changed[enbq_pkg::SW_BTN2]) begin
            if (role_stable[enbq_pkg::SW_BTN2]) begin
                n_hold      = '0;
                n_long_done = 1'b0;
            end else if (!r_long_done) begin
                b2_s = 1'b1;
            end
        end
        if (role_stable[enbq_pkg::SW_BTN2] && !n_long_done
                && enbq_pkg::CMP_BITS'(n_hold) > enbq_pkg::CMP_BITS'(r_long_ms)) begin
            b2_l        = 1'b1;
            n_long_done = 1'b1;
        end

        n_res.detent_step     = detent_step;
        n_res.raw_count       = raw_count;
        n_res.encoder_press   = enc_p;
        n_res.button1_press   = b1_p;
        n_res.button2_short   = b2_s;
        n_res.button2_long    = b2_l;
        n_res.endstop1_level  = role_stable[enbq_pkg::SW_ES1];
        n_res.endstop2_level  = role_stable[enbq_pkg::SW_ES2];
        n_res.endstop1_rise   = role_stable[enbq_pkg::SW_ES1] && !role_prev[enbq_pkg::SW_ES1];
        n_res.endstop2_rise   = role_stable[enbq_pkg::SW_ES2] && !role_prev[enbq_pkg::SW_ES2];
        n_res.user_activity   = (detent_step != enbq_pkg::DIR_NONE) || enc_p || b1_p
                                || b2_s || b2_l;
        n_res.endstop_changed = role_changed[enbq_pkg::SW_ES1] || role_changed[enbq_pkg::SW_ES2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold      <= '0;
            r_long_done <= 1'b0;
        end else if (in_xfer) begin
            r_hold      <= n_hold;
            r_long_done <= n_long_done;
        end
    end

    // result queue, head at entry 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            unique case ({in_xfer, out_xfer})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case ({in_xfer, out_xfer})
            2'b10: begin
                if (r_cnt == 2'd0) begin
                    r_q[0] <= n_res;
                end else begin
                    r_q[1] <= n_res;
                end
            end
            2'b01: r_q[0] <= r_q[1];
            2'b11: begin
                if (r_cnt == 2'd1) begin
                    r_q[0] <= n_res;
                end else begin
                    r_q[0] <= r_q[1];
                    r_q[1] <= n_res;
                end
            end
            default: ;
        endcase
    end

    assign o_detent_step     = r_q[0].detent_step;
    assign o_raw_count       = r_q[0].raw_count;
    assign o_encoder_press   = r_q[0].encoder_press;
    assign o_button1_press   = r_q[0].button1_press;
    assign o_button2_short   = r_q[0].button2_short;
    assign o_button2_long    = r_q[0].button2_long;
    assign o_endstop1_level  = r_q[0].endstop1_level;
    assign o_endstop2_level  = r_q[0].endstop2_level;
    assign o_endstop1_rise   = r_q[0].endstop1_rise;
    assign o_endstop2_rise   = r_q[0].endstop2_rise;
    assign o_user_activity   = r_q[0].user_activity;
    assign o_endstop_changed = r_q[0].endstop_changed;

endmodule

// File: rtl/enbq_checker.sv
// Port-level checks for the encoder and button qualifier, bound to the top.
// Depends on encoder_and_button_qualifier_top ports only.
module enbq_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_valid,
    input logic              i_ready,
    input logic signed [1:0] o_detent_step,
    input logic              o_encoder_press,
    input logic              o_button1_press,
    input logic              o_button2_short,
    input logic              o_button2_long,
    input logic              o_endstop1_level,
    input logic              o_endstop1_rise,
    input logic              o_endstop2_level,
    input logic              o_endstop2_rise,
    input logic              o_user_activity
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped while stalled");

    a_short_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_button2_short && o_button2_long))
        else $error("short and long pulse in one result");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_detent_step != 2'b10)
        else $error("detent step out of range");

    a_rise_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_endstop1_rise || o_endstop2_rise)
        |-> (!o_endstop1_rise || o_endstop1_level) && (!o_endstop2_rise || o_endstop2_level))
        else $error("endstop rise without active level");

    a_activity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_user_activity == ((o_detent_step != 2'b00) || o_encoder_press
            || o_button1_press || o_button2_short || o_button2_long))
        else $error("activity flag mismatch");

endmodule

bind encoder_and_button_qualifier_top enbq_checker u_enbq_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_detent_step    (o_detent_step),
    .o_encoder_press  (o_encoder_press),
    .o_button1_press  (o_button1_press),
    .o_button2_short  (o_button2_short),
    .o_button2_long   (o_button2_long),
    .o_endstop1_level (o_endstop1_level),
    .o_endstop1_rise  (o_endstop1_rise),
    .o_endstop2_level (o_endstop2_level),
    .o_endstop2_rise  (o_endstop2_rise),
    .o_user_activity  (o_user_activity)
);
